// ----- src/brake_light_controller_defines.svh -----
// Assertion macros for the brake light controller. They sample on clock and
// are disabled while reset is high.
`ifndef BRAKE_LIGHT_CONTROLLER_DEFINES_SVH
`define BRAKE_LIGHT_CONTROLLER_DEFINES_SVH

// Consequent checked at the same edge as the antecedent.
`define BLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked at the next edge after the antecedent.
`define BLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/blc_pkg.sv -----
package blc_pkg;

   // light modes
   localparam logic [1:0] LIGHT_STEADY = 2'd0;
   localparam logic [1:0] LIGHT_LOW    = 2'd1;
   localparam logic [1:0] LIGHT_STROBE = 2'd2;
   localparam logic [1:0] LIGHT_DARK   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_HIGH_LEVEL      = 3'd0;
   localparam logic [2:0] REG_MEDIUM_LEVEL    = 3'd1;
   localparam logic [2:0] REG_LOW_LEVEL       = 3'd2;
   localparam logic [2:0] REG_IDLE_LEVEL      = 3'd3;
   localparam logic [2:0] REG_RELEASE_HOLD_MS = 3'd4;
   localparam logic [2:0] REG_IDLE_DELAY_MS   = 3'd5;
   localparam logic [2:0] REG_LOW_VOLTAGE_DV  = 3'd6;
   localparam logic [2:0] REG_BRAKE_CURRENT   = 3'd7;

   localparam int unsigned CSR_ADDR_BITS = 5;

   localparam int unsigned DEBOUNCE_MS      = 70;
   localparam int unsigned STROBE_PERIOD_MS = 400;
   localparam int unsigned STROBE_ON_MS     = 200;
   localparam logic signed [31:0] BRAKE_RPM = 32'sd100;
   localparam logic signed [31:0] STILL_RPM = 32'sd10;
   localparam logic [2:0] CONFIRM_COUNT     = 3'd4;

   typedef struct packed {
      logic [7:0]  high_level;
      logic [7:0]  medium_level;
      logic [7:0]  low_level;
      logic [7:0]  idle_level;
      logic [15:0] release_hold_ms;
      logic [15:0] idle_delay_ms;
      logic [9:0]  low_voltage_dv;
      logic [10:0] brake_current_da;
   } cfg_type;

   typedef struct packed {
      logic [31:0]        time_ms;
      logic               button_level;
      logic               sample_valid;
      logic signed [31:0] motor_rpm;
      logic signed [15:0] motor_current_da;
      logic [9:0]         supply_dv;
   } item_type;

   typedef struct packed {
      logic [7:0] dimmer_level;
      logic       level_written;
      logic [1:0] light_mode;
      logic       braking;
      logic       idle_flag;
      logic       blanked;
   } rsp_type;

   typedef struct packed {
      logic [7:0] level;
      logic       wrote;
   } lvl_type;

   // drive a level; blanking forces zero, and any change marks the item
   function automatic lvl_type set_lvl(lvl_type s, logic blank, logic [7:0] v);
      lvl_type    r;
      logic [7:0] lv;
      r  = s;
      lv = blank ? 8'd0 : v;
      if (lv != s.level) begin
         r.level = lv;
         r.wrote = 1'b1;
      end
      return r;
   endfunction

   function automatic lvl_type apply_mode(lvl_type s, logic brake, logic blank,
                                          logic [1:0] mode, cfg_type cfg);
      lvl_type r;
      r = s;
      if (!brake) begin
         case (mode)
            LIGHT_STEADY: r = set_lvl(s, blank, cfg.medium_level);
            LIGHT_LOW:    r = set_lvl(s, blank, cfg.low_level);
            LIGHT_STROBE: r = set_lvl(s, blank, cfg.high_level);
            default:      r = set_lvl(s, blank, 8'd0);
         endcase
      end
      return r;
   endfunction

endpackage

// ----- src/blc_csr.sv -----
module blc_csr
   import blc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff;
   logic [2:0] idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_level       <= 8'd255;
         cfg_ff.medium_level     <= 8'd128;
         cfg_ff.low_level        <= 8'd40;
         cfg_ff.idle_level       <= 8'd20;
         cfg_ff.release_hold_ms  <= 16'd1000;
         cfg_ff.idle_delay_ms    <= 16'd5000;
         cfg_ff.low_voltage_dv   <= 10'd225;
         cfg_ff.brake_current_da <= 11'd120;
      end else if (wr_en) begin
         case (idx)
            REG_HIGH_LEVEL:      cfg_ff.high_level       <= csr_pwdata[7:0];
            REG_MEDIUM_LEVEL:    cfg_ff.medium_level     <= csr_pwdata[7:0];
            REG_LOW_LEVEL:       cfg_ff.low_level        <= csr_pwdata[7:0];
            REG_IDLE_LEVEL:      cfg_ff.idle_level       <= csr_pwdata[7:0];
            REG_RELEASE_HOLD_MS: cfg_ff.release_hold_ms  <= csr_pwdata[15:0];
            REG_IDLE_DELAY_MS:   cfg_ff.idle_delay_ms    <= csr_pwdata[15:0];
            REG_LOW_VOLTAGE_DV:  cfg_ff.low_voltage_dv   <= csr_pwdata[9:0];
            REG_BRAKE_CURRENT:   cfg_ff.brake_current_da <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_HIGH_LEVEL:      csr_prdata = {24'd0, cfg_ff.high_level};
         REG_MEDIUM_LEVEL:    csr_prdata = {24'd0, cfg_ff.medium_level};
         REG_LOW_LEVEL:       csr_prdata = {24'd0, cfg_ff.low_level};
         REG_IDLE_LEVEL:      csr_prdata = {24'd0, cfg_ff.idle_level};
         REG_RELEASE_HOLD_MS: csr_prdata = {16'd0, cfg_ff.release_hold_ms};
         REG_IDLE_DELAY_MS:   csr_prdata = {16'd0, cfg_ff.idle_delay_ms};
         REG_LOW_VOLTAGE_DV:  csr_prdata = {22'd0, cfg_ff.low_voltage_dv};
         REG_BRAKE_CURRENT:   csr_prdata = {21'd0, cfg_ff.brake_current_da};
         default:             csr_prdata = 32'd0;
      endcase
   end

endmodule

// ----- src/blc_core.sv -----
module blc_core
   import blc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  item_type item,
   input  cfg_type  cfg,
   output rsp_type  result
);

   logic                 btn_last_ff, btn_last_in;
   logic                 btn_stable_ff, btn_stable_in;
   logic [TIME_BITS-1:0] btn_time_ff, btn_time_in;
   logic [1:0]           mode_ff, mode_in;
   logic                 brake_ff, brake_in;
   logic                 idle_ff, idle_in;
   logic                 blank_ff, blank_in;
   logic [2:0]           count_ff, count_in;
   logic                 idle_vld_ff, idle_vld_in;
   logic                 rel_vld_ff, rel_vld_in;
   logic                 strobe_vld_ff, strobe_vld_in;
   logic [TIME_BITS-1:0] idle_start_ff, idle_start_in;
   logic [TIME_BITS-1:0] rel_start_ff, rel_start_in;
   logic [TIME_BITS-1:0] strobe_start_ff, strobe_start_in;
   logic [7:0]           drive_ff, drive_in;

   always_comb begin
      lvl_type              lv;
      logic [TIME_BITS-1:0] t;
      logic [TIME_BITS-1:0] el;
      logic signed [16:0]   cur_x;
      logic signed [16:0]   brake_thr;
      logic                 brake_hit;
      logic                 still_hit;

      t         = TIME_BITS'(item.time_ms);
      cur_x     = {item.motor_current_da[15], item.motor_current_da};
      brake_thr = -$signed({6'd0, cfg.brake_current_da});
      brake_hit = (cur_x < brake_thr) && (item.motor_rpm > BRAKE_RPM);
      still_hit = (item.motor_current_da == 16'sd0) && (item.motor_rpm < STILL_RPM)
                  && (item.motor_rpm > -STILL_RPM);

      lv.level        = drive_ff;
      lv.wrote        = 1'b0;
      btn_last_in     = item.button_level;
      btn_stable_in   = btn_stable_ff;
      btn_time_in     = btn_time_ff;
      mode_in         = mode_ff;
      brake_in        = brake_ff;
      idle_in         = idle_ff;
      blank_in        = blank_ff;
      count_in        = count_ff;
      idle_vld_in     = idle_vld_ff;
      rel_vld_in      = rel_vld_ff;
      strobe_vld_in   = strobe_vld_ff;
      idle_start_in   = idle_start_ff;
      rel_start_in    = rel_start_ff;
      strobe_start_in = strobe_start_ff;

      // button debounce, a settled press advances the mode
      if (item.button_level != btn_last_ff)
         btn_time_in = t;
      el = t - btn_time_in;
      if ((el > TIME_BITS'(DEBOUNCE_MS)) && (item.button_level != btn_stable_ff)) begin
         btn_stable_in = item.button_level;
         if (!item.button_level) begin
            mode_in = mode_ff + 2'd1;
            lv      = apply_mode(lv, brake_in, blank_in, mode_in, cfg);
         end
      end

      // strobe: on for the first part of each period, then idle level
      if ((mode_in == LIGHT_STROBE) && !brake_in && !idle_in) begin
         el = t - strobe_start_in;
         if (!strobe_vld_in || (el > TIME_BITS'(STROBE_PERIOD_MS))) begin
            strobe_start_in = t;
            strobe_vld_in   = 1'b1;
            lv              = set_lvl(lv, blank_in, cfg.high_level);
         end else if (el > TIME_BITS'(STROBE_ON_MS)) begin
            lv = set_lvl(lv, blank_in, cfg.idle_level);
         end
      end

      if ((mode_in != LIGHT_DARK) && item.sample_valid) begin
         if (brake_hit) begin
            if (count_in < CONFIRM_COUNT)
               count_in = count_in + 3'd1;
            idle_vld_in = 1'b0;
            if (!brake_in && (count_in >= CONFIRM_COUNT)) begin
               brake_in   = 1'b1;
               lv         = set_lvl(lv, blank_in, cfg.high_level);
               rel_vld_in = 1'b0;
            end
         end else begin
            count_in = 3'd0;
            if (still_hit) begin
               if (!idle_vld_in) begin
                  idle_start_in = t;
                  idle_vld_in   = 1'b1;
               end
            end else begin
               idle_vld_in = 1'b0;
               if (brake_in) begin
                  brake_in     = 1'b0;
                  rel_start_in = t;
                  rel_vld_in   = 1'b1;
               end
            end
         end

         // hold the brake light until the release time has run out
         el = t - rel_start_in;
         if (rel_vld_in && (el > TIME_BITS'(cfg.release_hold_ms))) begin
            rel_vld_in = 1'b0;
            if (!brake_in)
               lv = apply_mode(lv, brake_in, blank_in, mode_in, cfg);
         end

         el = t - idle_start_in;
         if (!idle_vld_in) begin
            if (idle_in) begin
               idle_in = 1'b0;
               lv      = apply_mode(lv, brake_in, blank_in, mode_in, cfg);
            end
         end else if (!idle_in && (el > TIME_BITS'(cfg.idle_delay_ms))) begin
            idle_in = 1'b1;
            lv      = set_lvl(lv, blank_in, cfg.idle_level);
         end

         // zero supply means no report
         if (item.supply_dv != 10'd0) begin
            if (item.supply_dv < cfg.low_voltage_dv) begin
               if (!blank_in) begin
                  blank_in = 1'b1;
                  lv       = set_lvl(lv, blank_in, 8'd0);
               end
            end else if (blank_in) begin
               blank_in = 1'b0;
               lv       = set_lvl(lv, blank_in, cfg.idle_level);
               lv       = apply_mode(lv, brake_in, blank_in, mode_in, cfg);
            end
         end
      end

      drive_in             = lv.level;
      result.dimmer_level  = lv.level;
      result.level_written = lv.wrote;
      result.light_mode    = mode_in;
      result.braking       = brake_in;
      result.idle_flag     = idle_in;
      result.blanked       = blank_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         btn_last_ff     <= 1'b1;
         btn_stable_ff   <= 1'b1;
         btn_time_ff     <= '0;
         mode_ff         <= LIGHT_STEADY;
         brake_ff        <= 1'b0;
         idle_ff         <= 1'b0;
         blank_ff        <= 1'b0;
         count_ff        <= 3'd0;
         idle_vld_ff     <= 1'b0;
         rel_vld_ff      <= 1'b0;
         strobe_vld_ff   <= 1'b0;
         idle_start_ff   <= '0;
         rel_start_ff    <= '0;
         strobe_start_ff <= '0;
         drive_ff        <= 8'd0;
      end else if (advance) begin
         btn_last_ff     <= btn_last_in;
         btn_stable_ff   <= btn_stable_in;
         btn_time_ff     <= btn_time_in;
         mode_ff         <= mode_in;
         brake_ff        <= brake_in;
         idle_ff         <= idle_in;
         blank_ff        <= blank_in;
         count_ff        <= count_in;
         idle_vld_ff     <= idle_vld_in;
         rel_vld_ff      <= rel_vld_in;
         strobe_vld_ff   <= strobe_vld_in;
         idle_start_ff   <= idle_start_in;
         rel_start_ff    <= rel_start_in;
         strobe_start_ff <= strobe_start_in;
         drive_ff        <= drive_in;
      end
   end

endmodule

// ----- src/brake_light_controller.sv -----
// Brake light controller. Each item is one pass of the control loop and yields
// exactly one result carrying the dimmer level, whether it changed, the light
// mode and the brake, idle and blanked flags. The block takes one item per clock
// while it does not stall: an item sits in the input register, is processed
// combinationally against the controller state, and lands in the result
// register at the edge where it advances. The result register lets a new item
// enter while a finished result waits; the input side stalls only when both
// registers are full. Registers sit on the APB-style port at byte address 4*i;
// write them only while no item is in flight. Timestamps wrap modulo 2^TIME_BITS.
`include "brake_light_controller_defines.svh"

module brake_light_controller
   import blc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_time_ms,
   input  logic                     req_button_level,
   input  logic                     req_sample_valid,
   input  logic signed [31:0]       req_motor_rpm,
   input  logic signed [15:0]       req_motor_current_da,
   input  logic [9:0]               req_supply_dv,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_dimmer_level,
   output logic                     rsp_level_written,
   output logic [1:0]               rsp_light_mode,
   output logic                     rsp_braking,
   output logic                     rsp_idle_flag,
   output logic                     rsp_blanked,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   cfg_type  cfg;
   item_type in_ff;
   logic     in_vld_ff;
   rsp_type  out_ff, step_rsp;
   logic     rsp_vld_ff;
   logic     advance;
   logic     blank_out;
   logic     full_stall;
   logic     idle_wr;

   assign advance   = in_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~in_vld_ff | advance;

   blc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   blc_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (req_ready)
            in_vld_ff <= req_valid;
         if (advance)
            rsp_vld_ff <= 1'b1;
         else if (rsp_ready)
            rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff.time_ms          <= req_time_ms;
         in_ff.button_level     <= req_button_level;
         in_ff.sample_valid     <= req_sample_valid;
         in_ff.motor_rpm        <= req_motor_rpm;
         in_ff.motor_current_da <= req_motor_current_da;
         in_ff.supply_dv        <= req_supply_dv;
      end
      if (advance)
         out_ff <= step_rsp;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_dimmer_level  = out_ff.dimmer_level;
   assign rsp_level_written = out_ff.level_written;
   assign rsp_light_mode    = out_ff.light_mode;
   assign rsp_braking       = out_ff.braking;
   assign rsp_idle_flag     = out_ff.idle_flag;
   assign rsp_blanked       = out_ff.blanked;

   assign blank_out  = rsp_valid & rsp_blanked;
   assign full_stall = in_vld_ff & rsp_vld_ff & ~rsp_ready;
   assign idle_wr    = ~reset & csr_psel & csr_penable & csr_pwrite
                       & (csr_paddr[CSR_ADDR_BITS-1:2] == REG_IDLE_LEVEL);

   `BLC_ASSERT_NOW(a_blank_dark, blank_out, rsp_dimmer_level == 8'd0, "lit while blanked")
   `BLC_ASSERT_NOW(a_full_stall, full_stall, !req_ready, "input taken while full")
   `BLC_ASSERT_NEXT(a_idle_wr, idle_wr, cfg.idle_level == $past(csr_pwdata[7:0]), "write lost")

endmodule
